/* hdl/assert_macros.svh */
// assertion macros shared by the neighbor context store
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assertion checked only while out of reset
`define CCN_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// assertion checked at every edge, reset included
`define CCN_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/ccn_pkg.sv */
// types and constants of the neighbor context store
package ccn_pkg;

    localparam int MAX_WIDTH_MBS_DEF = 256;
    localparam int PLANES_DEF        = 3;

    localparam int COUNT_W  = 5;
    localparam int ROW_W    = 4 * COUNT_W;
    localparam int WIDTH_W  = 9;
    localparam int CHROMA_W = 2;

    typedef enum logic [1:0] {
        CMD_FETCH   = 2'd0,
        CMD_STORE   = 2'd1,
        CMD_ADVANCE = 2'd2,
        CMD_RESTART = 2'd3
    } ccn_cmd_t;

    typedef enum logic [CHROMA_W-1:0] {
        CHROMA_MONO = 2'd0,
        CHROMA_420  = 2'd1,
        CHROMA_422  = 2'd2,
        CHROMA_444  = 2'd3
    } ccn_chroma_t;

    typedef enum logic {
        REG_CHROMA_FORMAT = 1'b0,
        REG_WIDTH_IN_MBS  = 1'b1
    } ccn_reg_t;

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } ccn_state_t;

    typedef struct packed {
        logic advance;
        logic restart;
    } ccn_pos_ctl_t;

endpackage

/* hdl/ccn_row_ram.sv */
// row line buffer: one port, synchronous write, registered read
module ccn_row_ram
    import ccn_pkg::*;
#(
    parameter int DEPTH  = MAX_WIDTH_MBS_DEF * PLANES_DEF,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic              clk,
    input  logic              we,
    input  logic              re,
    input  logic [ADDR_W-1:0] addr,
    input  logic [ROW_W-1:0]  wdata,
    output logic [ROW_W-1:0]  rdata
);

    logic [ROW_W-1:0] mem [DEPTH];
    logic [ROW_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/ccn_pos.sv */
// macroblock position tracker: column and first-row flag
module ccn_pos
    import ccn_pkg::*;
#(
    parameter int MAX_WIDTH_MBS = MAX_WIDTH_MBS_DEF,
    parameter int COL_W = (MAX_WIDTH_MBS > 1) ? $clog2(MAX_WIDTH_MBS) : 1
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  ccn_pos_ctl_t       ctl,
    input  logic [WIDTH_W-1:0] width_in_mbs,
    output logic [COL_W-1:0]   col,
    output logic               first_row
);

    localparam int EW = (COL_W + 1 > WIDTH_W) ? COL_W + 1 : WIDTH_W;

    logic [COL_W-1:0] col_reg, col_next;
    logic             first_row_reg, first_row_next;
    logic [EW-1:0]    eff_width;
    logic [EW-1:0]    col_inc;

    // width clamped to 1..MAX_WIDTH_MBS
    always_comb
    begin
        if (width_in_mbs == '0)
        begin
            eff_width = EW'(1);
        end
        else if (EW'(width_in_mbs) > EW'(MAX_WIDTH_MBS))
        begin
            eff_width = EW'(MAX_WIDTH_MBS);
        end
        else
        begin
            eff_width = EW'(width_in_mbs);
        end
    end

    assign col_inc = EW'(col_reg) + EW'(1);

    always_comb
    begin
        col_next       = col_reg;
        first_row_next = first_row_reg;
        if (ctl.restart)
        begin
            col_next       = '0;
            first_row_next = 1'b1;
        end
        else if (ctl.advance)
        begin
            if (col_inc >= eff_width)
            begin
                col_next       = '0;
                first_row_next = 1'b0;
            end
            else
            begin
                col_next = col_inc[COL_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            first_row_reg <= 1'b1;
        end
        else
        begin
            col_reg       <= col_next;
            first_row_reg <= first_row_next;
        end
    end

    assign col       = col_reg;
    assign first_row = first_row_reg;

endmodule

/* hdl/cavlc_coeff_count_neighbor_store.sv */
// Neighbor context store for CAVLC nC derivation. Commands arrive on the s_ group: fetch
// returns one result on the m_ group (left counts nA, upper counts nB), store, advance and
// restart return nothing. A fetch passes through a read state because the upper counts come
// from the row line buffer, a single-port memory with a registered read, and no request is
// taken during that read. A finished result waits in an output register while further
// requests are taken. The line buffer holds PLANES rows of MAX_WIDTH_MBS entries and
// needs no clearing pass; a fetch of an entry never stored is undefined. Registers: 0
// chroma_format, 1 width_in_mbs, to be written only while idle; the block does not enforce it.
module cavlc_coeff_count_neighbor_store
    import ccn_pkg::*;
#(
    parameter int MAX_WIDTH_MBS = MAX_WIDTH_MBS_DEF,
    parameter int PLANES        = PLANES_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [4*ROW_W-1:0] s_tdata,  // row_zero, row_one, row_two, row_three
    input  logic [3:0]         s_tuser,  // cmd, plane
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [2*ROW_W-1:0] m_tdata,  // left_counts, up_counts
    input  logic               cfg_we,
    input  logic [0:0]         cfg_index,
    input  logic [WIDTH_W-1:0] cfg_data
);

    `include "assert_macros.svh"

    localparam int COL_W  = (MAX_WIDTH_MBS > 1) ? $clog2(MAX_WIDTH_MBS) : 1;
    localparam int PL_W   = (PLANES > 1) ? $clog2(PLANES) : 1;
    localparam int DEPTH  = PLANES * MAX_WIDTH_MBS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    ccn_state_t           state_reg, state_next;
    ccn_chroma_t          chroma_reg;
    logic [WIDTH_W-1:0]   width_reg;
    logic [ROW_W-1:0]     left_store_reg [PLANES];
    logic [ROW_W-1:0]     pend_left_reg;
    logic                 pend_up_en_reg;
    logic                 m_valid_reg;
    logic [2*ROW_W-1:0]   m_data_reg;

    ccn_cmd_t             cmd;
    logic [1:0]           plane;
    logic [PL_W-1:0]      plane_idx;
    logic                 accept;
    logic                 present;
    logic [ROW_W-1:0]     rows [4];
    logic [1:0]           sel_col;
    logic [1:0]           sel_row;
    logic [ROW_W-1:0]     left_new;
    logic                 ram_we;
    logic                 ram_re;
    logic [ADDR_W-1:0]    ram_addr;
    logic [ROW_W-1:0]     ram_rdata;
    logic                 load_out;
    ccn_pos_ctl_t         pos_ctl;
    logic [COL_W-1:0]     col;
    logic                 first_row;

    assign cmd       = ccn_cmd_t'(s_tuser[1:0]);
    assign plane     = s_tuser[3:2];
    assign plane_idx = plane[PL_W-1:0];
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;

    assign rows[0] = s_tdata[0*ROW_W +: ROW_W];
    assign rows[1] = s_tdata[1*ROW_W +: ROW_W];
    assign rows[2] = s_tdata[2*ROW_W +: ROW_W];
    assign rows[3] = s_tdata[3*ROW_W +: ROW_W];

    // monochrome has luma only
    assign present = ((chroma_reg == CHROMA_MONO) ? (plane == 2'd0) : (plane != 2'd3))
                     && (32'(plane) < PLANES);

    always_comb
    begin
        if (plane == 2'd0)
        begin
            sel_col = 2'd3;
            sel_row = 2'd3;
        end
        else
        begin
            sel_col = (chroma_reg == CHROMA_444) ? 2'd3 : 2'd1;
            sel_row = (chroma_reg == CHROMA_420) ? 2'd1 : 2'd3;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            left_new[i*COUNT_W +: COUNT_W] = rows[i][sel_col*COUNT_W +: COUNT_W];
        end
    end

    assign pos_ctl.advance = accept && (cmd == CMD_ADVANCE);
    assign pos_ctl.restart = accept && (cmd == CMD_RESTART);

    ccn_pos #(
        .MAX_WIDTH_MBS (MAX_WIDTH_MBS),
        .COL_W         (COL_W)
    ) u_pos (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (pos_ctl),
        .width_in_mbs (width_reg),
        .col          (col),
        .first_row    (first_row)
    );

    assign ram_we   = accept && (cmd == CMD_STORE) && present;
    assign ram_re   = accept && (cmd == CMD_FETCH);
    assign ram_addr = ADDR_W'(plane_idx) * ADDR_W'(MAX_WIDTH_MBS) + ADDR_W'(col);

    ccn_row_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_row_ram (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (rows[sel_row]),
        .rdata (ram_rdata)
    );

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chroma_reg <= CHROMA_420;
            width_reg  <= WIDTH_W'(120);
        end
        else if (cfg_we)
        begin
            case (ccn_reg_t'(cfg_index))
                REG_CHROMA_FORMAT: chroma_reg <= ccn_chroma_t'(cfg_data[CHROMA_W-1:0]);
                REG_WIDTH_IN_MBS:  width_reg  <= cfg_data;
                default:           ;
            endcase
        end
    end

    // left column store and fetch capture
    always_ff @(posedge clk)
    begin
        if (ram_we)
        begin
            left_store_reg[plane_idx] <= left_new;
        end
        if (ram_re)
        begin
            pend_left_reg  <= (present && (col != '0)) ? left_store_reg[plane_idx] : '0;
            pend_up_en_reg <= present && !first_row;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        load_out   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (ram_re)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            m_data_reg <= {(pend_up_en_reg ? ram_rdata : {ROW_W{1'b0}}), pend_left_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    `CCN_ASSERT(a_fetch_blocks, clk, rst_n, ram_re |=> (state_reg == ST_READ) && !s_tready, "fetch did not start the line buffer read")
    `CCN_ASSERT(a_read_done, clk, rst_n, ((state_reg == ST_READ) && (!m_valid_reg || m_tready)) |=> m_valid_reg && (state_reg == ST_IDLE), "fetch result not delivered to output register")
    `CCN_ASSERT(a_port_excl, clk, rst_n, !(ram_we && ram_re), "line buffer read and write in one cycle")
    `CCN_ASSERT_NR(a_reset_out, clk, !rst_n |=> !m_valid_reg && (state_reg == ST_IDLE), "output or state not cleared in reset")

endmodule
